@@ sv/lavm_pkg.sv @@
// Shared constants and types for the look-at view matrix core.
`default_nettype none
package lavm_pkg;

  // Default coordinate width, Q(n-16).16
  localparam int COORD_WIDTH_DEF = 32;

  // Axis words are signed Q2.30
  localparam int AXIS_W = 32;
  localparam int FRAC_W = 30;
  localparam logic signed [AXIS_W-1:0] ONE_Q30 = 32'sd1073741824;

  // Stage counts of the pipeline parts
  localparam int NORM_LAT  = 71;
  localparam int CROSS_LAT = 2;
  localparam int ROUND_LAT = 2;
  localparam int XLAT_LAT  = 6;

  typedef logic signed [AXIS_W-1:0] axis_t;

endpackage
`default_nettype wire

@@ sv/lavm_delay.sv @@
// Enabled shift line that keeps side data aligned with the pipeline.
`default_nettype none
module lavm_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [0:DEPTH-1];

  // Shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule
`default_nettype wire

@@ sv/lavm_norm.sv @@
// Pipelined fixed-point vector normalise: scale, sum of squares, root, divide.
`default_nettype none
module lavm_norm
  import lavm_pkg::*;
#(
  parameter int W = 33
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] vin  [3],
  output axis_t               vout [3],
  output logic                ok
);

  localparam int PW = $clog2(W);
  localparam int MW = (W > FRAC_W) ? W : FRAC_W;
  localparam int SW = 1 + 3 + 3 * FRAC_W;
  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 31;

  logic [W-1:0]        mag1 [3];
  logic [2:0]          neg1;
  logic [W-1:0]        mag2 [3];
  logic [2:0]          neg2;
  logic [W-1:0]        mx2;
  logic [W-1:0]        mx_next;
  logic [W-1:0]        mag3 [3];
  logic [2:0]          neg3;
  logic [PW-1:0]       p3;
  logic [PW-1:0]       p_next;
  logic                ok3;
  logic [FRAC_W-1:0]   m4 [3];
  logic [FRAC_W-1:0]   m4_next [3];
  logic [2:0]          neg4;
  logic                ok4;
  logic [2*FRAC_W-1:0] sq5 [3];
  logic [FRAC_W-1:0]   m5 [3];
  logic [2:0]          neg5;
  logic                ok5;

  logic [63:0]         sn    [0:SQ_STEPS];
  logic [63:0]         sr    [0:SQ_STEPS];
  logic [SW-1:0]       sside [0:SQ_STEPS];

  logic [63:0]         drem [0:DV_STEPS][3];
  logic [30:0]         dq   [0:DV_STEPS][3];
  logic [31:0]         dl   [0:DV_STEPS];
  logic [3:0]          dsd  [0:DV_STEPS];

  // Stage 1: component magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= vin[i][W-1] ? (~vin[i] + 1'b1) : vin[i];
        neg1[i] <= vin[i][W-1];
      end
    end
  end

  // Stage 2: largest magnitude
  always_comb begin
    mx_next = mag1[0];
    if (mag1[1] > mx_next) mx_next = mag1[1];
    if (mag1[2] > mx_next) mx_next = mag1[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx2  <= mx_next;
      mag2 <= mag1;
      neg2 <= neg1;
    end
  end

  // Stage 3: top set bit of the largest
  always_comb begin
    p_next = '0;
    for (int b = 0; b < W; b++) begin
      if (mx2[b]) p_next = PW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3   <= p_next;
      ok3  <= (mx2 != '0);
      mag3 <= mag2;
      neg3 <= neg2;
    end
  end

  // Stage 4: common shift, top bit to bit 29
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (int'(p3) > FRAC_W - 1) begin
        m4_next[i] = FRAC_W'(MW'(mag3[i]) >> (int'(p3) - (FRAC_W - 1)));
      end else begin
        m4_next[i] = FRAC_W'(MW'(mag3[i]) << ((FRAC_W - 1) - int'(p3)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m4   <= m4_next;
      neg4 <= neg3;
      ok4  <= ok3;
    end
  end

  // Stage 5: squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq5[i] <= m4[i] * m4[i];
      end
      m5   <= m4;
      neg5 <= neg4;
      ok5  <= ok4;
    end
  end

  // Stage 6: sum of squares enters the root pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      sn[0]    <= 64'(sq5[0]) + 64'(sq5[1]) + 64'(sq5[2]);
      sr[0]    <= '0;
      sside[0] <= {ok5, neg5, m5[2], m5[1], m5[0]};
    end
  end

  // Integer square root, one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    always_ff @(posedge clk) begin
      if (en) begin
        if (sn[k] >= sr[k] + BIT) begin
          sn[k+1] <= sn[k] - (sr[k] + BIT);
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sn[k+1] <= sn[k];
          sr[k+1] <= sr[k] >> 1;
        end
        sside[k+1] <= sside[k];
      end
    end
  end

  // Dividend with half the length added for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= (64'(sside[SQ_STEPS][i*FRAC_W +: FRAC_W]) << FRAC_W)
                    + (sr[SQ_STEPS] >> 1);
        dq[0][i]   <= '0;
      end
      dl[0]  <= sr[SQ_STEPS][31:0];
      dsd[0] <= sside[SQ_STEPS][SW-1 -: 4];
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
    localparam int SH = DV_STEPS - 1 - j;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (drem[j][i] >= (64'(dl[j]) << SH)) begin
            drem[j+1][i] <= drem[j][i] - (64'(dl[j]) << SH);
            dq[j+1][i]   <= {dq[j][i][29:0], 1'b1};
          end else begin
            drem[j+1][i] <= drem[j][i];
            dq[j+1][i]   <= {dq[j][i][29:0], 1'b0};
          end
        end
        dl[j+1]  <= dl[j];
        dsd[j+1] <= dsd[j];
      end
    end
  end

  // Apply signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vout[i] <= dsd[DV_STEPS][i] ? -$signed({1'b0, dq[DV_STEPS][i]})
                                    : $signed({1'b0, dq[DV_STEPS][i]});
      end
      ok <= dsd[DV_STEPS][3];
    end
  end

endmodule
`default_nettype wire

@@ sv/lavm_cross.sv @@
// Two-stage cross product of Q2.30 vectors, exact Q4.60 result.
`default_nettype none
module lavm_cross
  import lavm_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  axis_t              a [3],
  input  axis_t              b [3],
  output logic signed [63:0] c [3]
);

  logic signed [63:0] p [6];

  // Partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= 64'(a[1] * b[2]);
      p[1] <= 64'(a[2] * b[1]);
      p[2] <= 64'(a[2] * b[0]);
      p[3] <= 64'(a[0] * b[2]);
      p[4] <= 64'(a[0] * b[1]);
      p[5] <= 64'(a[1] * b[0]);
    end
  end

  // Differences
  always_ff @(posedge clk) begin
    if (en) begin
      c[0] <= p[0] - p[1];
      c[1] <= p[2] - p[3];
      c[2] <= p[4] - p[5];
    end
  end

endmodule
`default_nettype wire

@@ sv/lavm_xlat.sv @@
// Translation column: rounded axis-by-eye products, summed, negated, saturated.
`default_nettype none
module lavm_xlat
  import lavm_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  axis_t                ax  [9],
  input  logic signed [CW-1:0] eye [3],
  output logic signed [CW-1:0] shift [3]
);

  localparam int EW = 48;
  localparam int HW = EW - FRAC_W;
  localparam logic signed [52:0] MAXV = 53'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [52:0] MINV = -MAXV - 53'sd1;

  logic [30:0]        am [9];
  logic [EW-1:0]      em [9];
  logic [8:0]         ng1;
  logic [48:0]        ph [9];
  logic [60:0]        pl [9];
  logic [8:0]         ng2;
  logic [49:0]        r3 [9];
  logic [8:0]         ng3;
  logic signed [50:0] t4 [9];
  logic signed [52:0] s5 [3];

  // T1: magnitudes and product signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          am[j*3+i]  <= ax[j*3+i][31] ? 31'(-ax[j*3+i]) : 31'(ax[j*3+i]);
          em[j*3+i]  <= EW'($unsigned(eye[i][CW-1] ? -eye[i] : eye[i]));
          ng1[j*3+i] <= ax[j*3+i][31] ^ eye[i][CW-1];
        end
      end
    end
  end

  // T2: high and low partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        ph[k] <= am[k] * em[k][EW-1 -: HW];
        pl[k] <= am[k] * em[k][FRAC_W-1:0];
      end
      ng2 <= ng1;
    end
  end

  // T3: round the low part to Q.16
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        r3[k] <= 50'(ph[k]) + 50'((62'(pl[k]) + (62'd1 << (FRAC_W - 1))) >> FRAC_W);
      end
      ng3 <= ng2;
    end
  end

  // T4: signed terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        t4[k] <= ng3[k] ? -$signed({1'b0, r3[k]}) : $signed({1'b0, r3[k]});
      end
    end
  end

  // T5: negated row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s5[j] <= -(53'(t4[j*3]) + 53'(t4[j*3+1]) + 53'(t4[j*3+2]));
      end
    end
  end

  // T6: saturate to the coordinate range
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        if (s5[j] > MAXV) begin
          shift[j] <= CW'(MAXV);
        end else if (s5[j] < MINV) begin
          shift[j] <= CW'(MINV);
        end else begin
          shift[j] <= CW'(s5[j]);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/look_at_view_matrix_core.sv @@
// Look-at view matrix core: one camera request in, one view matrix out.
//
// Input channel: in_valid / in_stall with eye, aim and hint coordinates, each
// a signed Q(COORD_WIDTH-16).16 word. Output channel: out_valid / out_stall
// with the right, true up and back rows in signed Q2.30 and the translation
// column shift_x/y/z in Q(COORD_WIDTH-16).16, saturated.
// A transaction takes place on a clock edge where valid is high and stall low.
// Degenerate requests (eye on aim, zero hint, hint along the view axis) give
// an all-zero matrix.
// The pipeline depth is set by the two normalise units in series, each a
// 32-stage square root followed by a 31-stage divider.
// Throughput is one request per cycle while out_stall holds no waiting result.
// Reset (rst, synchronous) empties the pipeline; no request is in flight after.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module look_at_view_matrix_core
  import lavm_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] eye_x,
  input  logic signed [COORD_WIDTH-1:0] eye_y,
  input  logic signed [COORD_WIDTH-1:0] eye_z,
  input  logic signed [COORD_WIDTH-1:0] aim_x,
  input  logic signed [COORD_WIDTH-1:0] aim_y,
  input  logic signed [COORD_WIDTH-1:0] aim_z,
  input  logic signed [COORD_WIDTH-1:0] hint_x,
  input  logic signed [COORD_WIDTH-1:0] hint_y,
  input  logic signed [COORD_WIDTH-1:0] hint_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            right_x,
  output logic signed [31:0]            right_y,
  output logic signed [31:0]            right_z,
  output logic signed [31:0]            true_up_x,
  output logic signed [31:0]            true_up_y,
  output logic signed [31:0]            true_up_z,
  output logic signed [31:0]            back_x,
  output logic signed [31:0]            back_y,
  output logic signed [31:0]            back_z,
  output logic signed [COORD_WIDTH-1:0] shift_x,
  output logic signed [COORD_WIDTH-1:0] shift_y,
  output logic signed [COORD_WIDTH-1:0] shift_z
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int VW  = 3 * AXIS_W;
  localparam int LAT = 2 * NORM_LAT + 2 * CROSS_LAT + ROUND_LAT + XLAT_LAT + 1;

  logic                 en;
  logic [LAT-1:0]       vline;

  logic signed [DW-1:0] d0   [3];
  logic signed [CW-1:0] h0   [3];
  logic signed [CW-1:0] e0   [3];

  axis_t                back_n [3];
  axis_t                hint_n [3];
  logic                 back_ok;
  logic                 hint_ok;
  logic signed [63:0]   c1 [3];
  axis_t                right_n [3];
  logic                 right_ok;
  logic                 pre_ok;
  logic                 all_ok;

  logic [VW-1:0]        back_p1;
  axis_t                back_d1 [3];
  logic [VW-1:0]        back_p2;
  logic [VW-1:0]        right_p1;
  logic [VW-1:0]        up_p;
  logic [3*CW-1:0]      eye_p;
  logic [VW-1:0]        back_q;
  logic [VW-1:0]        right_q;
  logic [VW-1:0]        up_q;

  logic signed [63:0]   c2 [3];
  logic [63:0]          umag [3];
  logic [2:0]           uneg;
  axis_t                up_n [3];
  logic [33:0]          urnd [3];

  axis_t                xax  [9];
  logic signed [CW-1:0] xeye [3];
  logic signed [CW-1:0] xsh  [3];

  // Whole pipeline advances unless a finished result is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vline[LAT-1];

  // Valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else if (en) begin
      vline <= {vline[LAT-2:0], in_valid};
    end
  end

  // Entry stage: view direction, hint and eye registered
  always_ff @(posedge clk) begin
    if (en) begin
      d0[0] <= DW'(eye_x) - DW'(aim_x);
      d0[1] <= DW'(eye_y) - DW'(aim_y);
      d0[2] <= DW'(eye_z) - DW'(aim_z);
      h0[0] <= hint_x;
      h0[1] <= hint_y;
      h0[2] <= hint_z;
      e0[0] <= eye_x;
      e0[1] <= eye_y;
      e0[2] <= eye_z;
    end
  end

  // Back and hint normalised side by side
  lavm_norm #(.W(DW)) u_norm_back (
    .clk(clk), .en(en), .vin(d0), .vout(back_n), .ok(back_ok)
  );

  lavm_norm #(.W(CW)) u_norm_hint (
    .clk(clk), .en(en), .vin(h0), .vout(hint_n), .ok(hint_ok)
  );

  // hint x back
  lavm_cross u_cross_side (
    .clk(clk), .en(en), .a(hint_n), .b(back_n), .c(c1)
  );

  lavm_norm #(.W(64)) u_norm_right (
    .clk(clk), .en(en), .vin(c1), .vout(right_n), .ok(right_ok)
  );

  // Back held until right is ready
  lavm_delay #(.W(VW), .DEPTH(NORM_LAT + CROSS_LAT)) u_dly_back1 (
    .clk(clk), .en(en), .din({back_n[2], back_n[1], back_n[0]}), .dout(back_p1)
  );

  assign back_d1[0] = back_p1[0*AXIS_W +: AXIS_W];
  assign back_d1[1] = back_p1[1*AXIS_W +: AXIS_W];
  assign back_d1[2] = back_p1[2*AXIS_W +: AXIS_W];

  lavm_delay #(.W(1), .DEPTH(NORM_LAT + CROSS_LAT)) u_dly_ok1 (
    .clk(clk), .en(en), .din(back_ok && hint_ok), .dout(pre_ok)
  );

  // back x right gives the true up
  lavm_cross u_cross_up (
    .clk(clk), .en(en), .a(back_d1), .b(right_n), .c(c2)
  );

  // Round the true up to Q2.30, half away from zero, and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        umag[i] <= c2[i][63] ? 64'(-c2[i]) : 64'(c2[i]);
        uneg[i] <= c2[i][63];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      urnd[i] = 34'((umag[i] + (64'd1 << (FRAC_W - 1))) >> FRAC_W);
      if (urnd[i] > 34'(ONE_Q30)) urnd[i] = 34'(ONE_Q30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        up_n[i] <= uneg[i] ? -AXIS_W'(urnd[i]) : AXIS_W'(urnd[i]);
      end
    end
  end

  // Align right, back and eye with the true up
  lavm_delay #(.W(VW), .DEPTH(CROSS_LAT + ROUND_LAT)) u_dly_right1 (
    .clk(clk), .en(en), .din({right_n[2], right_n[1], right_n[0]}), .dout(right_p1)
  );

  lavm_delay #(.W(VW), .DEPTH(CROSS_LAT + ROUND_LAT)) u_dly_back2 (
    .clk(clk), .en(en), .din(back_p1), .dout(back_p2)
  );

  lavm_delay #(.W(3*CW), .DEPTH(2 * NORM_LAT + 2 * CROSS_LAT + ROUND_LAT)) u_dly_eye (
    .clk(clk), .en(en), .din({e0[2], e0[1], e0[0]}), .dout(eye_p)
  );

  assign up_p = {up_n[2], up_n[1], up_n[0]};

  // Translation column
  for (genvar i = 0; i < 3; i++) begin : g_xin
    assign xax[i]   = right_p1[i*AXIS_W +: AXIS_W];
    assign xax[3+i] = up_p[i*AXIS_W +: AXIS_W];
    assign xax[6+i] = back_p2[i*AXIS_W +: AXIS_W];
    assign xeye[i]  = eye_p[i*CW +: CW];
  end

  lavm_xlat #(.CW(CW)) u_xlat (
    .clk(clk), .en(en), .ax(xax), .eye(xeye), .shift(xsh)
  );

  // Rows and flag follow the translation stages
  lavm_delay #(.W(VW), .DEPTH(XLAT_LAT)) u_dly_right2 (
    .clk(clk), .en(en), .din(right_p1), .dout(right_q)
  );

  lavm_delay #(.W(VW), .DEPTH(XLAT_LAT)) u_dly_up (
    .clk(clk), .en(en), .din(up_p), .dout(up_q)
  );

  lavm_delay #(.W(VW), .DEPTH(XLAT_LAT)) u_dly_back3 (
    .clk(clk), .en(en), .din(back_p2), .dout(back_q)
  );

  lavm_delay #(.W(1), .DEPTH(CROSS_LAT + ROUND_LAT + XLAT_LAT)) u_dly_ok2 (
    .clk(clk), .en(en), .din(pre_ok && right_ok), .dout(all_ok)
  );

  // Degenerate requests give zeros
  assign right_x   = all_ok ? right_q[0*AXIS_W +: AXIS_W] : '0;
  assign right_y   = all_ok ? right_q[1*AXIS_W +: AXIS_W] : '0;
  assign right_z   = all_ok ? right_q[2*AXIS_W +: AXIS_W] : '0;
  assign true_up_x = all_ok ? up_q[0*AXIS_W +: AXIS_W] : '0;
  assign true_up_y = all_ok ? up_q[1*AXIS_W +: AXIS_W] : '0;
  assign true_up_z = all_ok ? up_q[2*AXIS_W +: AXIS_W] : '0;
  assign back_x    = all_ok ? back_q[0*AXIS_W +: AXIS_W] : '0;
  assign back_y    = all_ok ? back_q[1*AXIS_W +: AXIS_W] : '0;
  assign back_z    = all_ok ? back_q[2*AXIS_W +: AXIS_W] : '0;
  assign shift_x   = all_ok ? xsh[0] : '0;
  assign shift_y   = all_ok ? xsh[1] : '0;
  assign shift_z   = all_ok ? xsh[2] : '0;

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(shift_x) && $stable(right_x))
    else $error("held result changed under stall");

  a_right_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (right_x <= ONE_Q30) && (right_x >= -ONE_Q30))
    else $error("right axis outside unit range");

  a_up_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (true_up_y <= ONE_Q30) && (true_up_y >= -ONE_Q30))
    else $error("true up outside unit range");

endmodule
`default_nettype wire
